FILE: sv/ttpt_pkg.sv
package ttpt_pkg;

   localparam int unsigned PERIOD_W = 20;
   localparam int unsigned AMOUNT_W = 20;
   localparam int unsigned TICKS_W  = 21;
   localparam int unsigned OP_W     = 3;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 20;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_STOP   = 3'd1;
   localparam logic [OP_W-1:0] OP_RESUME = 3'd2;
   localparam logic [OP_W-1:0] OP_PHASE  = 3'd3;
   localparam logic [OP_W-1:0] OP_FREQ   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 2'd1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd20000;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_TOCK = 1'b1;

   typedef struct packed {
      logic signed [AMOUNT_W-1:0] phase_clamped;
      logic [TICKS_W-1:0]         tx_reload;
      logic [TICKS_W-1:0]         rx_reload;
   } calc_type;

endpackage

FILE: sv/ttpt_if.sv
interface ttpt_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [ttpt_pkg::OP_W-1:0]                 operation;
   logic signed [ttpt_pkg::AMOUNT_W-1:0]      amount;

   modport source (output valid, output operation, output amount, input ready);
   modport sink (input valid, input operation, input amount, output ready);
endinterface

interface ttpt_rsp_if;
   logic valid;
   logic ready;
   logic event_kind;

   modport source (output valid, output event_kind, input ready);
   modport sink (input valid, input event_kind, output ready);
endinterface

interface ttpt_csr_if;
   logic                               valid;
   logic                               ready;
   logic [ttpt_pkg::CSR_IDX_W-1:0]     index;
   logic [ttpt_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: sv/tick_tock_phase_trim_timer.sv
// Microsecond alarm timer for a radio link.
// req channel: one request per cycle unless a response is stalled, operation plus signed amount. Operation
//   tick advances time by one microsecond; stop, resume, phase request and
//   frequency offset are commands. Unknown operations are dropped.
// rsp channel: event_kind, 0 = tick alarm, 1 = tock alarm. At most one
//   response per request, only for a tick request that fires an alarm.
// csr channel: index 0 = period_us, index 1 = transmitter_mode; always ready,
//   one write per cycle; write only while no request is in flight.
// Latency: a response is valid the cycle after its request is accepted.
// Throughput: one request per cycle while no response is stalled; all state updates
//   go through the reload/clamp logic into the state and response registers.
// Stall: while a response waits with rsp.ready low, req.ready is low; it is
//   high again in the cycle the response is taken.
// Reset: timer stopped, ticks_left, phase and trim cleared, period_us = 20000,
//   receiver mode, no response pending.
module tick_tock_phase_trim_timer (
   input  logic        clock,
   input  logic        reset,
   ttpt_req_if.sink    req_ch,
   ttpt_rsp_if.source  rsp_ch,
   ttpt_csr_if.sink    csr_ch
);

   logic [ttpt_pkg::PERIOD_W-1:0]        period_us_ff, period_us_in;
   logic                                 transmitter_mode_ff, transmitter_mode_in;
   logic [ttpt_pkg::TICKS_W-1:0]         ticks_left_ff, ticks_left_in;
   logic                                 is_running_ff, is_running_in;
   logic                                 next_is_tick_ff, next_is_tick_in;
   logic signed [ttpt_pkg::AMOUNT_W-1:0] pending_phase_ff, pending_phase_in;
   logic signed [ttpt_pkg::AMOUNT_W-1:0] frequency_trim_ff, frequency_trim_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_event_kind_ff, rsp_event_kind_in;

   logic               accept;
   logic               fire;
   ttpt_pkg::calc_type calc;

   ttpt_calc u_calc (
      .period_us      (period_us_ff),
      .amount         (req_ch.amount),
      .frequency_trim (frequency_trim_ff),
      .pending_phase  (pending_phase_ff),
      .next_is_tick   (next_is_tick_ff),
      .calc           (calc)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept = req_ch.valid && req_ch.ready;
   assign fire = accept && (req_ch.operation == ttpt_pkg::OP_TICK) && is_running_ff
              && (ticks_left_ff <= ttpt_pkg::TICKS_W'(1));

   assign csr_ch.ready = 1'b1;

   always_comb begin
      period_us_in        = period_us_ff;
      transmitter_mode_in = transmitter_mode_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            ttpt_pkg::REG_PERIOD: period_us_in = csr_ch.data;
            ttpt_pkg::REG_MODE:   transmitter_mode_in = csr_ch.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ticks_left_in     = ticks_left_ff;
      is_running_in     = is_running_ff;
      next_is_tick_in   = next_is_tick_ff;
      pending_phase_in  = pending_phase_ff;
      frequency_trim_in = frequency_trim_ff;
      rsp_event_kind_in = rsp_event_kind_ff;
      if (accept) begin
         case (req_ch.operation)
            ttpt_pkg::OP_STOP: is_running_in = 1'b0;
            ttpt_pkg::OP_RESUME: begin
               if (!is_running_ff) begin
                  is_running_in = 1'b1;
                  if (transmitter_mode_ff) begin
                     ticks_left_in = calc.tx_reload;
                  end else begin
                     ticks_left_in   = ttpt_pkg::TICKS_W'(1);
                     next_is_tick_in = 1'b0;
                  end
               end
            end
            ttpt_pkg::OP_PHASE: pending_phase_in = calc.phase_clamped;
            ttpt_pkg::OP_FREQ:  frequency_trim_in = req_ch.amount;
            ttpt_pkg::OP_TICK: begin
               if (is_running_ff) begin
                  if (ticks_left_ff > ttpt_pkg::TICKS_W'(1)) begin
                     ticks_left_in = ticks_left_ff - ttpt_pkg::TICKS_W'(1);
                  end else if (transmitter_mode_ff) begin
                     ticks_left_in     = calc.tx_reload;
                     rsp_event_kind_in = ttpt_pkg::KIND_TOCK;
                  end else begin
                     ticks_left_in   = calc.rx_reload;
                     next_is_tick_in = !next_is_tick_ff;
                     if (next_is_tick_ff) begin
                        rsp_event_kind_in = ttpt_pkg::KIND_TICK;
                     end else begin
                        rsp_event_kind_in = ttpt_pkg::KIND_TOCK;
                        pending_phase_in  = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_us_ff        <= ttpt_pkg::PERIOD_RESET;
         transmitter_mode_ff <= 1'b0;
         ticks_left_ff       <= '0;
         is_running_ff       <= 1'b0;
         next_is_tick_ff     <= 1'b0;
         pending_phase_ff    <= '0;
         frequency_trim_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         period_us_ff        <= period_us_in;
         transmitter_mode_ff <= transmitter_mode_in;
         ticks_left_ff       <= ticks_left_in;
         is_running_ff       <= is_running_in;
         next_is_tick_ff     <= next_is_tick_in;
         pending_phase_ff    <= pending_phase_in;
         frequency_trim_ff   <= frequency_trim_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_event_kind_ff <= rsp_event_kind_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.event_kind = rsp_event_kind_ff;

   a_stopped_no_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && !is_running_ff |=> !rsp_valid_ff)
      else $error("response from a stopped timer");

   a_tx_tock_only: assert property (@(posedge clock) disable iff (reset)
      fire && transmitter_mode_ff |=> rsp_valid_ff && rsp_event_kind_ff == ttpt_pkg::KIND_TOCK)
      else $error("transmitter alarm is not a tock");

   a_phase_cleared: assert property (@(posedge clock) disable iff (reset)
      fire && !transmitter_mode_ff && !next_is_tick_ff |=> pending_phase_ff == '0)
      else $error("phase shift not cleared after tock");

   a_reload_nonzero: assert property (@(posedge clock) disable iff (reset)
      fire |=> ticks_left_ff != '0)
      else $error("alarm reload left zero ticks");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("request accepted over a stalled response");

endmodule

FILE: sv/ttpt_calc.sv
module ttpt_calc (
   input  logic [ttpt_pkg::PERIOD_W-1:0]        period_us,
   input  logic signed [ttpt_pkg::AMOUNT_W-1:0] amount,
   input  logic signed [ttpt_pkg::AMOUNT_W-1:0] frequency_trim,
   input  logic signed [ttpt_pkg::AMOUNT_W-1:0] pending_phase,
   input  logic                                 next_is_tick,
   output ttpt_pkg::calc_type                   calc
);

   logic signed [ttpt_pkg::AMOUNT_W-1:0] lim;
   logic signed [ttpt_pkg::AMOUNT_W-1:0] neg_lim;
   logic signed [ttpt_pkg::TICKS_W:0]    gap;
   logic signed [ttpt_pkg::TICKS_W:0]    phase_term;

   assign lim     = $signed({2'b00, period_us[ttpt_pkg::PERIOD_W-1:2]});
   assign neg_lim = -lim;

   // add phase only on the gap after a tock
   assign phase_term = next_is_tick ? '0 : {{2{pending_phase[ttpt_pkg::AMOUNT_W-1]}},
                                            pending_phase};

   assign gap = $signed({3'b000, period_us[ttpt_pkg::PERIOD_W-1:1]})
              + $signed({{2{frequency_trim[ttpt_pkg::AMOUNT_W-1]}}, frequency_trim})
              + phase_term;

   always_comb begin
      if (amount > lim) begin
         calc.phase_clamped = lim;
      end else if (amount < neg_lim) begin
         calc.phase_clamped = neg_lim;
      end else begin
         calc.phase_clamped = amount;
      end

      if (period_us == '0) begin
         calc.tx_reload = ttpt_pkg::TICKS_W'(1);
      end else begin
         calc.tx_reload = {1'b0, period_us};
      end

      if (gap < $signed((ttpt_pkg::TICKS_W+1)'(1))) begin
         calc.rx_reload = ttpt_pkg::TICKS_W'(1);
      end else begin
         calc.rx_reload = gap[ttpt_pkg::TICKS_W-1:0];
      end
   end

endmodule
